[hw/rtl/sws_pkg.sv]
// Shared types and constants for the sliding window sender tracker.
// No dependencies; imported by every module of the block.
package sws_pkg;

  localparam int SEQ_W     = 31;
  localparam int TIME_W    = 32;
  localparam int WIN_W     = 9;
  localparam int ACT_W     = 3;
  localparam int REQ_W     = 2;
  localparam int RWIN_W    = 20;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int DIVC_W    = 5;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 104;

  localparam logic [TIME_W-1:0]    RTO_DEV_FLOOR = 32'd10000;
  localparam logic [TIME_W-1:0]    RTO_RESET     = 32'd1000000;
  localparam logic [CNT_W-1:0]     DUP_TRIGGER   = 8'd3;
  localparam logic [CNT_W-1:0]     CNT_MAX       = 8'd255;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RTO = 2'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_SEND  = 2'd0,
    REQ_ACK   = 2'd1,
    REQ_TIMER = 2'd2
  } req_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_SENT    = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_TIMEOUT = 3'd3,
    ACT_FAST    = 3'd4,
    ACT_GIVE_UP = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEND,
    OP_ACK_SAMPLE,
    OP_ACK_PLAIN,
    OP_DUP_FAST,
    OP_TIMER
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_START,
    S_DIV,
    S_MEM,
    S_CALC1,
    S_CALC2,
    S_CALC3,
    S_TCHK,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic mem_go;
    logic calc1;
    logic calc2;
    logic calc3;
    logic tchk;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_read;
    logic sample;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

[hw/rtl/sws_mod.sv]
// Bit-serial modulo unit: sequence number mod window size, one bit per cycle.
// Depends on sws_pkg.
module sws_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sws_pkg::SEQ_W-1:0]  num_i,
  input  logic [sws_pkg::WIN_W-1:0]  den_i,
  output logic                       done_o,
  output logic [sws_pkg::WIN_W-1:0]  rem_o
);
  import sws_pkg::*;

  logic [SEQ_W-1:0]  num_q, num_d;
  logic [WIN_W-1:0]  den_q, den_d;
  logic [WIN_W-1:0]  rem_q, rem_d;
  logic [DIVC_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [WIN_W:0]    trial;

  always_comb begin
    trial  = {rem_q, num_q[SEQ_W-1]};
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = DIVC_W'(SEQ_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      num_d = {num_q[SEQ_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = WIN_W'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[WIN_W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIVC_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/sws_ctrl.sv]
// Sequencing state machine for one item: evaluate, slot lookup, stamp access, update.
// Depends on sws_pkg.
module sws_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sws_pkg::dp_status_t    status_i,
  output sws_pkg::ctrl_cmd_t     cmd_o
);
  import sws_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_EVAL;
      S_EVAL:   state_d = S_START;
      S_START:  state_d = status_i.need_div ? S_DIV : S_FINISH;
      S_DIV:    if (status_i.div_done) state_d = S_MEM;
      S_MEM: begin
        if (!status_i.need_read) state_d = S_FINISH;
        else if (status_i.sample) state_d = S_CALC1;
        else state_d = S_TCHK;
      end
      S_CALC1:  state_d = S_CALC2;
      S_CALC2:  state_d = S_CALC3;
      S_CALC3:  state_d = S_FINISH;
      S_TCHK:   state_d = S_FINISH;
      S_FINISH: if (!status_i.out_busy) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EVAL:   cmd_o.eval = 1'b1;
      S_START:  cmd_o.div_start = status_i.need_div;
      S_MEM:    cmd_o.mem_go = 1'b1;
      S_CALC1:  cmd_o.calc1 = 1'b1;
      S_CALC2:  cmd_o.calc2 = 1'b1;
      S_CALC3:  cmd_o.calc3 = 1'b1;
      S_TCHK:   cmd_o.tchk = 1'b1;
      S_FINISH: cmd_o.finish = !status_i.out_busy;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/sws_datapath.sv]
// Window state, stamp memory, RTO estimator and result register.
// Depends on sws_pkg and sws_mod.
module sws_datapath #(
  parameter int WINDOW_DEPTH = 256,
  parameter int MAX_RETRIES  = 50
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sws_pkg::ctrl_cmd_t                cmd_i,
  output sws_pkg::dp_status_t               status_o,
  input  logic [sws_pkg::REQ_W-1:0]         req_type_i,
  input  logic [sws_pkg::TIME_W-1:0]        now_time_i,
  input  logic [sws_pkg::SEQ_W-1:0]         ack_seq_i,
  input  logic                              fin_flag_i,
  input  logic [sws_pkg::RWIN_W-1:0]        receiver_window_i,
  input  logic                              cfg_we_i,
  input  logic [sws_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sws_pkg::TIME_W-1:0]        cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sws_pkg::ACT_W-1:0]         action_o,
  output logic [sws_pkg::TIME_W-1:0]        seq_out_o,
  output logic [sws_pkg::SEQ_W-1:0]         acked_count_o,
  output logic [sws_pkg::WIN_W-1:0]         window_out_o,
  output logic [sws_pkg::TIME_W-1:0]        rto_out_o
);
  import sws_pkg::*;

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [CNT_W-1:0] GIVE_UP_RUN = CNT_W'(MAX_RETRIES - 1);

  // latched item
  logic [REQ_W-1:0]  req_q;
  logic [TIME_W-1:0] now_q;
  logic [SEQ_W-1:0]  ack_q;
  logic              fin_q;
  logic [RWIN_W-1:0] rwin_q;

  // protocol state
  logic [WIN_W-1:0]  win_size_q;
  logic [TIME_W-1:0] base_q;
  logic [SEQ_W-1:0]  next_q;
  logic [TIME_W-1:0] srtt_q, dev_q, cur_rto_q;
  logic [CNT_W-1:0]  dup_cnt_q, tout_run_q;
  logic [TIME_W-1:0] rtx_total_q, rtx_snap_q;
  logic [WIN_W-1:0]  eff_win_q;

  // per-item work
  op_e               op_q;
  logic [ACT_W-1:0]  act_q;
  logic [SEQ_W-1:0]  div_num_q;
  logic [SEQ_W-1:0]  seq_res_q;
  logic [SEQ_W-1:0]  acked_q;
  logic [TIME_W-1:0] rd_q;

  // result register
  logic              out_valid_q;
  logic [ACT_W-1:0]  out_act_q;
  logic [TIME_W-1:0] out_seq_q;
  logic [SEQ_W-1:0]  out_acked_q;
  logic [WIN_W-1:0]  out_win_q;
  logic [TIME_W-1:0] out_rto_q;

  logic [TIME_W-1:0] stamp_mem [WINDOW_DEPTH];

  logic              div_done;
  logic [WIN_W-1:0]  div_rem;
  logic [SLOT_W-1:0] slot;

  logic [TIME_W-1:0] ack_t;
  logic              ack_ok, dup_hit, outstanding, timed_out;
  logic [SEQ_W-1:0]  base_nn;
  logic [CNT_W-1:0]  dup_inc, tout_inc;
  logic [TIME_W-1:0] elapsed, sample_r, diff, dev_floor;
  logic [TIME_W+2:0] srtt_w;
  logic [TIME_W+1:0] dev_w;
  logic [TIME_W+2:0] rto_w;
  logic [WIN_W-1:0]  cfg_win, eff_new;
  logic              mem_we;

  sws_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num_q),
    .den_i   (win_size_q),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  assign slot = SLOT_W'(div_rem);

  always_comb begin
    ack_t       = {1'b0, ack_q} + {{(TIME_W-1){1'b0}}, fin_q};
    ack_ok      = ($signed({1'b0, ack_t}) > $signed({base_q[TIME_W-1], base_q}))
                  && (ack_t <= {1'b0, next_q});
    dup_hit     = !base_q[TIME_W-1] && (ack_q == base_q[SEQ_W-1:0]);
    base_nn     = base_q[TIME_W-1] ? '0 : base_q[SEQ_W-1:0];
    outstanding = next_q > base_nn;
    dup_inc     = (dup_cnt_q == CNT_MAX) ? CNT_MAX : dup_cnt_q + 1'b1;
    tout_inc    = (tout_run_q == CNT_MAX) ? CNT_MAX : tout_run_q + 1'b1;
    eff_new     = ({{(RWIN_W-WIN_W){1'b0}}, win_size_q} < rwin_q) ? win_size_q
                                                                 : rwin_q[WIN_W-1:0];
    elapsed     = now_q - rd_q;
    timed_out   = elapsed >= cur_rto_q;
    sample_r    = elapsed;
    srtt_w      = ({3'b0, srtt_q} << 3) - {3'b0, srtt_q} + {3'b0, sample_r};
    diff        = (sample_r >= srtt_q) ? sample_r - srtt_q : srtt_q - sample_r;
    dev_w       = ({2'b0, dev_q} << 1) + {2'b0, dev_q} + {2'b0, diff};
    dev_floor   = (dev_q > RTO_DEV_FLOOR) ? dev_q : RTO_DEV_FLOOR;
    rto_w       = {3'b0, srtt_q} + {1'b0, dev_floor, 2'b00};
    cfg_win     = (cfg_data_i[WIN_W-1:0] == '0) ? WIN_W'(1) : cfg_data_i[WIN_W-1:0];
    if ({23'b0, cfg_win} > 32'(WINDOW_DEPTH)) begin
      cfg_win = WIN_W'(WINDOW_DEPTH);
    end
    mem_we = (cmd_i.mem_go && (op_q == OP_SEND || op_q == OP_DUP_FAST))
             || (cmd_i.tchk && timed_out);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stamp_mem[slot] <= now_q;
    end
    if (cmd_i.mem_go) begin
      rd_q <= stamp_mem[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      now_q  <= now_time_i;
      ack_q  <= ack_seq_i;
      fin_q  <= fin_flag_i;
      rwin_q <= receiver_window_i;
    end
    if (cmd_i.eval) begin
      seq_res_q <= next_q;
      acked_q   <= '0;
      div_num_q <= base_nn;
      if (req_q == REQ_SEND) begin
        div_num_q <= next_q;
      end else if (req_q == REQ_ACK && ack_ok) begin
        acked_q   <= ack_q - base_q[SEQ_W-1:0];
        div_num_q <= (ack_q == '0) ? '0 : ack_q - 1'b1;
      end
    end
    if (cmd_i.finish) begin
      out_act_q   <= act_q;
      out_seq_q   <= (op_q == OP_SEND) ? {1'b0, seq_res_q} : base_q;
      out_acked_q <= acked_q;
      out_win_q   <= eff_win_q;
      out_rto_q   <= cur_rto_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q  <= WIN_W'(1);
      base_q      <= '1;
      next_q      <= '0;
      srtt_q      <= '0;
      dev_q       <= '0;
      cur_rto_q   <= RTO_RESET;
      dup_cnt_q   <= '0;
      tout_run_q  <= '0;
      rtx_total_q <= '0;
      rtx_snap_q  <= '0;
      eff_win_q   <= WIN_W'(1);
      op_q        <= OP_NONE;
      act_q       <= ACT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_SIZE: win_size_q <= cfg_win;
          CFG_INITIAL_RTO: cur_rto_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.eval) begin
        op_q  <= OP_NONE;
        act_q <= ACT_NONE;
        case (req_q)
          REQ_SEND: begin
            op_q   <= OP_SEND;
            act_q  <= ACT_SENT;
            next_q <= next_q + 1'b1;
          end
          REQ_ACK: begin
            if (ack_ok) begin
              act_q      <= ACT_ACK;
              base_q     <= {1'b0, ack_q};
              eff_win_q  <= eff_new;
              dup_cnt_q  <= '0;
              tout_run_q <= '0;
              if (rtx_snap_q == rtx_total_q) begin
                op_q <= OP_ACK_SAMPLE;
              end else begin
                op_q       <= OP_ACK_PLAIN;
                rtx_snap_q <= rtx_total_q;
              end
            end else if (dup_hit) begin
              dup_cnt_q <= dup_inc;
              if (dup_inc == DUP_TRIGGER) begin
                op_q        <= OP_DUP_FAST;
                act_q       <= ACT_FAST;
                tout_run_q  <= '0;
                rtx_total_q <= rtx_total_q + 1'b1;
              end
            end
          end
          REQ_TIMER: begin
            if (outstanding) op_q <= OP_TIMER;
          end
          default: ;
        endcase
      end
      if (cmd_i.tchk && timed_out) begin
        tout_run_q  <= tout_inc;
        rtx_total_q <= rtx_total_q + 1'b1;
        act_q       <= (tout_inc >= GIVE_UP_RUN) ? ACT_GIVE_UP : ACT_TIMEOUT;
      end
      if (cmd_i.calc1) srtt_q <= srtt_w[TIME_W+2:3];
      if (cmd_i.calc2) dev_q  <= dev_w[TIME_W+1:2];
      if (cmd_i.calc3) cur_rto_q <= (rto_w[TIME_W+2:TIME_W] != 3'b000) ? '1
                                                                       : rto_w[TIME_W-1:0];
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.need_div  = (op_q == OP_SEND) || (op_q == OP_ACK_SAMPLE)
                              || (op_q == OP_DUP_FAST) || (op_q == OP_TIMER);
  assign status_o.need_read = (op_q == OP_ACK_SAMPLE) || (op_q == OP_TIMER);
  assign status_o.sample    = (op_q == OP_ACK_SAMPLE);
  assign status_o.div_done  = div_done;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_act_q;
  assign seq_out_o     = out_seq_q;
  assign acked_count_o = out_acked_q;
  assign window_out_o  = out_win_q;
  assign rto_out_o     = out_rto_q;

  a_win_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_size_q != '0) && ({23'b0, win_size_q} <= 32'(WINDOW_DEPTH)))
    else $error("window size out of range");

  a_fast_on_third_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == OP_DUP_FAST) |-> (dup_cnt_q == DUP_TRIGGER))
    else $error("fast retransmit without third duplicate");

  a_rto_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.calc3 |=> (cur_rto_q >= 32'd40000))
    else $error("sampled rto below floor");

endmodule

[hw/rtl/sliding_window_sender_tracker_unit.sv]
// Steps (accepting edge to result valid): EVAL, START, FINISH for items that touch
// no stamp slot; other items add DIV and MEM, plus TCHK for timer checks or
// CALC1-CALC3 for sampled acks; the 31-step bit-serial slot modulo (sequence mod
// window_size) in DIV dominates. Throughput: one item at a time, the next taken in
// the cycle after the result is registered; the result register frees the input.
// Reset: asynchronous, active low; clears control and window state; stamp memory
// has no reset value; the user must only read slots written before, not enforced.
module sliding_window_sender_tracker_unit #(
  parameter int WINDOW_DEPTH = 256,
  parameter int MAX_RETRIES  = 50
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_time[31:0], ack_seq[62:32], fin_flag[63], receiver_window[83:64]
  input  logic [sws_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type[1:0]
  input  logic [sws_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // seq_out[31:0], acked_count[62:32], window_out[71:63], rto_out[103:72]
  output logic [sws_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // action[2:0]
  output logic [sws_pkg::ACT_W-1:0]          m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [sws_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sws_pkg::TIME_W-1:0]         cfg_data_i
);
  import sws_pkg::*;

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [TIME_W-1:0] seq_out, rto_out;
  logic [SEQ_W-1:0]  acked_count;
  logic [WIN_W-1:0]  window_out;

  sws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sws_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_RETRIES  (MAX_RETRIES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .req_type_i        (s_axis_tuser),
    .now_time_i        (s_axis_tdata[31:0]),
    .ack_seq_i         (s_axis_tdata[62:32]),
    .fin_flag_i        (s_axis_tdata[63]),
    .receiver_window_i (s_axis_tdata[83:64]),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .action_o          (m_axis_tuser),
    .seq_out_o         (seq_out),
    .acked_count_o     (acked_count),
    .window_out_o      (window_out),
    .rto_out_o         (rto_out)
  );

  assign m_axis_tdata = {rto_out, window_out, acked_count, seq_out};

endmodule

[bench/sliding_window_sender_tracker_unit_tb.sv]
// Self-checking bench for sliding_window_sender_tracker_unit: directed and random
// send/ack/timer items checked against an in-bench window and RTO tracker.
// Depends on sws_pkg and the unit RTL only.
`timescale 1ns / 1ps

module sliding_window_sender_tracker_unit_tb;
  import sws_pkg::*;

  localparam logic [REQ_W-1:0]     REQ_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED3 = 2'd3;
  localparam int N_SLOTS   = 256;
  localparam int GIVE_UP_AT = 49;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [31:0]       now;
    logic [30:0]       ack;
    logic              fin;
    logic [19:0]       rwin;
  } req_item_t;

  typedef struct {
    action_e     act;
    logic [31:0] seq;
    logic [30:0] acked;
    logic [8:0]  win;
    logic [31:0] rto;
  } track_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [REQ_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [ACT_W-1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [TIME_W-1:0] cfg_data = '0;

  sliding_window_sender_tracker_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always #5 clk = ~clk;

  // tracker state
  int unsigned win_size, rto_init;
  longint base_seq;
  longint unsigned next_seq;
  logic [31:0] stamp_mem [N_SLOTS];
  bit stamp_set [N_SLOTS];
  longint unsigned srtt, rttvar, rto_cur;
  int unsigned dup_cnt, to_run;
  logic [31:0] retx_total, retx_snap;
  int unsigned eff_win;
  logic [31:0] clk_us;

  track_res_t pending_res[$];
  int errors = 0;
  int hold_cycles = 0;
  int stall_pct = 0;

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic int unsigned slot_of(input longint s);
    if (s < 0) s = 0;
    return int'(s % win_size);
  endfunction

  function automatic bit is_valid_ack(input req_item_t it);
    longint t;
    t = longint'(it.ack) + longint'(it.fin);
    return t > base_seq && t <= longint'(next_seq);
  endfunction

  function automatic bit reads_unwritten(input req_item_t it);
    longint b;
    if (it.req == REQ_ACK && is_valid_ack(it) && retx_snap == retx_total)
      return !stamp_set[slot_of(longint'(it.ack) - 1)];
    if (it.req == REQ_TIMER) begin
      b = base_seq < 0 ? 0 : base_seq;
      if (longint'(next_seq) > b) return !stamp_set[slot_of(base_seq)];
    end
    return 1'b0;
  endfunction

  task automatic rtt_update(input logic [31:0] r);
    longint unsigned s, d, v, t;
    s = (7 * srtt + r) >> 3;
    d = (r >= s) ? r - s : s - r;
    v = (3 * rttvar + d) >> 2;
    t = s + 4 * (v > 10000 ? v : 10000);
    srtt = s;
    rttvar = v;
    rto_cur = t > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : t;
  endtask

  task automatic track_step(input req_item_t it, output track_res_t r);
    int unsigned s;
    longint b;
    r.act = ACT_NONE;
    r.acked = '0;
    r.seq = base_seq[31:0];
    case (it.req)
      REQ_SEND: begin
        s = slot_of(longint'(next_seq));
        stamp_mem[s] = it.now;
        stamp_set[s] = 1'b1;
        r.seq = next_seq[31:0];
        next_seq = (next_seq + 1) & 64'h7FFF_FFFF;
        r.act = ACT_SENT;
      end
      REQ_ACK: begin
        if (is_valid_ack(it)) begin
          r.acked = 31'(longint'(it.ack) - base_seq);
          base_seq = longint'(it.ack);
          eff_win = longint'(win_size) < longint'(it.rwin) ? win_size : it.rwin;
          dup_cnt = 0;
          to_run = 0;
          if (retx_snap == retx_total)
            rtt_update(it.now - stamp_mem[slot_of(longint'(it.ack) - 1)]);
          else
            retx_snap = retx_total;
          r.act = ACT_ACK;
          r.seq = base_seq[31:0];
        end else if (longint'(it.ack) == base_seq) begin
          if (dup_cnt < 255) dup_cnt++;
          if (dup_cnt == 3) begin
            to_run = 0;
            retx_total++;
            s = slot_of(base_seq);
            stamp_mem[s] = it.now;
            stamp_set[s] = 1'b1;
            r.act = ACT_FAST;
          end
        end
      end
      REQ_TIMER: begin
        b = base_seq < 0 ? 0 : base_seq;
        if (longint'(next_seq) > b) begin
          s = slot_of(base_seq);
          if (32'(it.now - stamp_mem[s]) >= rto_cur[31:0]) begin
            if (to_run < 255) to_run++;
            retx_total++;
            stamp_mem[s] = it.now;
            r.act = to_run >= GIVE_UP_AT ? ACT_GIVE_UP : ACT_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
    r.win = eff_win[8:0];
    r.rto = rto_cur[31:0];
  endtask

  // one item on the input stream; valid is left high after acceptance
  task automatic send_item(input req_item_t it);
    track_res_t r;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = it.req;
    s_tdata = {4'b0, it.rwin, it.fin, it.ack, it.now};
    do @(posedge clk); while (!s_tready);
    track_step(it, r);
    pending_res.push_back(r);
  endtask

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
  endtask

  task automatic drain();
    idle(1);
    wait (pending_res.size() == 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    int unsigned v;
    drain();
    idle(60);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_WINDOW_SIZE) begin
      v = val[8:0];
      win_size = v < 1 ? 1 : (v > N_SLOTS ? N_SLOTS : v);
    end else if (idx == CFG_INITIAL_RTO) begin
      rto_init = val;
      rto_cur = val;
    end
  endtask

  function automatic req_item_t mk(input logic [REQ_W-1:0] req, input logic [31:0] now,
                                   input logic [30:0] ack, input logic fin,
                                   input logic [19:0] rwin);
    req_item_t it;
    it.req = req; it.now = now; it.ack = ack; it.fin = fin; it.rwin = rwin;
    return it;
  endfunction

  task automatic gen_random(output req_item_t it);
    int unsigned pick, span;
    longint t;
    pick = $urandom_range(0, 99);
    clk_us += $urandom_range(1, 3000);
    it = mk(REQ_SEND, clk_us, $urandom, $urandom_range(0, 1),
            $urandom_range(0, 7) == 0 ? 20'($urandom) : 20'($urandom_range(0, 300)));
    if ($urandom_range(0, 29) == 0) it.now = $urandom;
    if (pick < 38) begin
      it.req = REQ_SEND;
    end else if (pick < 70) begin
      it.req = REQ_ACK;
      if (longint'(next_seq) > base_seq) begin
        span = longint'(next_seq) - base_seq - 1;
        t = base_seq + 1 + ($urandom_range(0, 3) == 0 ? span :
                            $urandom_range(0, span > 4 ? 4 : span));
        it.fin = ($urandom_range(0, 9) == 0) && t > 0;
        it.ack = 31'(t - it.fin);
      end
    end else if (pick < 80) begin
      it.req = REQ_ACK;
      it.fin = 1'b0;
      if (base_seq >= 0) it.ack = base_seq[30:0];
    end else if (pick < 84) begin
      it.req = REQ_ACK;
    end else if (pick < 96) begin
      it.req = REQ_TIMER;
      if ($urandom_range(0, 1) && stamp_set[slot_of(base_seq)])
        it.now = stamp_mem[slot_of(base_seq)] + rto_cur[31:0] + $urandom_range(0, 50);
    end else begin
      it.req = REQ_UNKNOWN;
    end
    if (reads_unwritten(it)) it.req = REQ_SEND;
    if (it.req != REQ_UNKNOWN && it.now > clk_us) clk_us = it.now;
  endtask

  task automatic run_random(input int n);
    req_item_t it;
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n > 0) begin
        gen_random(it);
        send_item(it);
        burst--;
        n--;
      end
      idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10));
    end
  endtask

  task automatic test_reset_state();
    send_item(mk(REQ_TIMER, 32'hFFFF_FFFF, '1, 1'b1, '1));
    send_item(mk(REQ_ACK, 32'd0, 31'h7FFF_FFFF, 1'b1, '1));
    send_item(mk(REQ_ACK, 32'd0, 31'd0, 1'b0, '0));
    send_item(mk(REQ_UNKNOWN, '1, '1, 1'b1, '1));
    send_item(mk(REQ_SEND, 32'd0, '0, 1'b0, '0));
    send_item(mk(REQ_ACK, 32'd500, 31'd0, 1'b1, 20'hFFFFF));
    send_item(mk(REQ_SEND, 32'hFFFF_FFFF, '1, 1'b1, '1));
    send_item(mk(REQ_ACK, 32'd100, 31'd1, 1'b0, 20'd0));
    clk_us = 32'd1000;
  endtask

  task automatic test_dup_and_karn();
    cfg_write(CFG_WINDOW_SIZE, 32'd8);
    for (int i = 0; i < 4; i++) send_item(mk(REQ_SEND, clk_us + i, '0, 1'b0, '0));
    for (int i = 0; i < 5; i++)
      send_item(mk(REQ_ACK, clk_us + 10 + i, base_seq[30:0], 1'b0, 20'd4));
    send_item(mk(REQ_ACK, clk_us + 900, 31'(next_seq - 1), 1'b0, 20'd300));
    send_item(mk(REQ_TIMER, clk_us + 950, '0, 1'b0, '0));
    send_item(mk(REQ_ACK, clk_us + 990, 31'(next_seq), 1'b0, 20'd6));
    clk_us += 2000;
  endtask

  task automatic test_give_up();
    cfg_write(CFG_INITIAL_RTO, 32'd1000);
    cfg_write(CFG_WINDOW_SIZE, 32'd4);
    send_item(mk(REQ_SEND, clk_us, '0, 1'b0, '0));
    send_item(mk(REQ_SEND, clk_us, '0, 1'b0, '0));
    for (int i = 0; i < 53; i++) begin
      clk_us += 32'd1000;
      send_item(mk(REQ_TIMER, clk_us, '0, 1'b0, '0));
    end
    clk_us += 10;
    send_item(mk(REQ_ACK, clk_us, 31'(next_seq), 1'b0, 20'd2));
  endtask

  task automatic test_backpressure();
    hold_cycles = 500;
    run_random(40);
    drain();
  endtask

  task automatic test_config_sweep();
    cfg_write(CFG_WINDOW_SIZE, 32'd0);
    run_random(150);
    cfg_write(CFG_WINDOW_SIZE, 32'd256);
    cfg_write(CFG_INITIAL_RTO, 32'hFFFF_FFFF);
    run_random(400);
    cfg_write(CFG_WINDOW_SIZE, 32'h1FF);
    cfg_write(CFG_INITIAL_RTO, 32'd1);
    run_random(300);
    cfg_write(CFG_UNUSED2, 32'hFFFF_FFFF);
    cfg_write(CFG_UNUSED3, 32'd0);
    cfg_write(CFG_WINDOW_SIZE, 32'd1);
    cfg_write(CFG_INITIAL_RTO, 32'd0);
    run_random(200);
    cfg_write(CFG_WINDOW_SIZE, 32'd37);
    cfg_write(CFG_INITIAL_RTO, 32'd20000);
    run_random(700);
  endtask

  always begin
    @(negedge clk);
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready = 1'b0;
    end else begin
      m_tready = $urandom_range(0, 99) >= stall_pct;
    end
  end

  always begin
    repeat (300) @(posedge clk);
    case ($urandom_range(0, 2))
      0: stall_pct = 0;
      1: stall_pct = 30;
      default: stall_pct = 70;
    endcase
  end

  always @(posedge clk) begin
    track_res_t e;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_res.size() == 0) begin
        report("result with no item pending");
      end else begin
        e = pending_res.pop_front();
        if (m_tuser !== e.act)
          report($sformatf("action %0d, want %0d", m_tuser, e.act));
        if (m_tdata[31:0] !== e.seq)
          report($sformatf("seq_out %0h, want %0h", m_tdata[31:0], e.seq));
        if (m_tdata[62:32] !== e.acked)
          report($sformatf("acked_count %0h, want %0h", m_tdata[62:32], e.acked));
        if (m_tdata[71:63] !== e.win)
          report($sformatf("window_out %0d, want %0d", m_tdata[71:63], e.win));
        if (m_tdata[103:72] !== e.rto)
          report($sformatf("rto_out %0d, want %0d", m_tdata[103:72], e.rto));
      end
    end
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    win_size = 1; rto_init = 1000000;
    base_seq = -1; next_seq = 0;
    srtt = 0; rttvar = 0; rto_cur = rto_init;
    dup_cnt = 0; to_run = 0; retx_total = 0; retx_snap = 0; eff_win = 1;
    clk_us = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      stamp_mem[i] = '0;
      stamp_set[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_dup_and_karn();
    test_give_up();
    test_backpressure();
    test_config_sweep();
    drain();
    repeat (80) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
